@@ hw/rtl/mat_pkg.sv @@
// ----------------------------------------------------------------------------
// mat_pkg: shared types and constants of the multi-turn angle tracker
// beat payloads, configuration struct, register indexes and reading kinds
// ----------------------------------------------------------------------------
package mat_pkg;

	// configuration register indexes
	localparam logic CFG_SENSOR_WIDTH_MODE = 1'b0;
	localparam logic CFG_SPEED_GAIN        = 1'b1;

	localparam int CFG_DATA_W = 16;

	// reset values of the configuration registers
	localparam logic             RST_SENSOR_WIDTH_MODE = 1'b0;
	localparam logic [15:0]      RST_SPEED_GAIN        = 16'd256;

	// sensor width modes
	localparam logic MODE_12BIT = 1'b0;
	localparam logic MODE_14BIT = 1'b1;

	// reading kinds carried by an input beat
	typedef enum logic [1:0] {
		KIND_NONE       = 2'd0,
		KIND_POSITION   = 2'd1,
		KIND_STATUS_POS = 2'd2,
		KIND_UNUSED     = 2'd3
	} kind_t;

	// status byte bit positions of the 12-bit sensor
	localparam int STAT_MH = 3;
	localparam int STAT_ML = 4;
	localparam int STAT_MD = 5;

	// speed saturation limits (24-bit signed)
	localparam int SPEED_MAX = 8388607;
	localparam int SPEED_MIN = -8388608;

	// gain is unsigned Q8.8
	localparam int GAIN_FRAC_BITS = 8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [13:0] raw_angle;
		logic [7:0]  status_byte;
		logic [15:0] error_word;
	} item_t;

	typedef struct packed {
		logic [15:0]        angle_fraction;
		logic signed [15:0] turn_count;
		logic signed [31:0] displacement;
		logic signed [23:0] speed;
		logic               magnet_fault;
		logic [15:0]        error_flags;
	} result_t;

	typedef struct packed {
		logic        sensor_width_mode;
		logic [15:0] speed_gain;
	} cfg_t;

endpackage

@@ hw/rtl/mat_update.sv @@
// ----------------------------------------------------------------------------
// mat_update: next-state and result logic of the multi-turn angle tracker
// unwraps one reading against the held angle, scales speed, builds the result
// ----------------------------------------------------------------------------
module mat_update
	import mat_pkg::*;
#(
	parameter int FRACTION_BITS = 16,
	parameter int TURN_BITS     = 16
) (
	input  cfg_t                     cfg,
	input  item_t                    item,
	input  logic [FRACTION_BITS-1:0] angle,
	input  logic [TURN_BITS-1:0]     turns,
	input  logic signed [23:0]       speed,
	input  logic signed [31:0]       displacement,
	input  logic                     magnet,
	input  logic [15:0]              err_latch,
	output logic [FRACTION_BITS-1:0] angle_next,
	output logic [TURN_BITS-1:0]     turns_next,
	output logic signed [23:0]       speed_next,
	output logic signed [31:0]       displacement_next,
	output logic                     magnet_next,
	output logic [15:0]              err_latch_next,
	output result_t                  result
);

	localparam int FB       = FRACTION_BITS;
	localparam int PW       = FB + 18;
	localparam int FRAC_UP  = (FB < 16) ? 16 - FB : 0;
	localparam int FRAC_DN  = (FB >= 16) ? FB - 16 : 0;
	localparam logic signed [FB:0]   HALF     = (FB+1)'(1 << (FB - 1));
	localparam logic signed [FB:0]   NEG_HALF = -HALF;
	localparam logic        [FB:0]   WRAP     = {1'b1, {FB{1'b0}}};
	localparam logic signed [PW-1:0] SAT_HI   = PW'(SPEED_MAX);
	localparam logic signed [PW-1:0] SAT_LO   = PW'(SPEED_MIN);

	logic [FB-1:0]       fresh;
	logic                has_reading;
	logic                full;
	logic signed [FB:0]  diff_raw;
	logic signed [FB:0]  diff;
	logic                wrap_dn;
	logic                wrap_up;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] scaled;
	logic [15:0]         frac16;
	logic [15:0]         turns16;
	logic [3:0]          unused_stat;

	assign unused_stat = {item.status_byte[7:6], item.status_byte[2:1]} ^
		{3'b000, item.status_byte[0]};

	always_comb begin
		if (cfg.sensor_width_mode == MODE_12BIT) begin
			fresh = FB'(item.raw_angle[11:0]) << (FB - 12);
		end else begin
			fresh = FB'(item.raw_angle) << (FB - 14);
		end
		has_reading = (item.kind == KIND_POSITION) || (item.kind == KIND_STATUS_POS);
		// plain position read of the 12-bit sensor only moves the angle
		full = has_reading &&
			!((cfg.sensor_width_mode == MODE_12BIT) && (item.kind == KIND_POSITION));

		diff_raw = $signed({1'b0, fresh}) - $signed({1'b0, angle});
		wrap_dn  = diff_raw < NEG_HALF;
		wrap_up  = diff_raw > HALF;
		// adding or taking away one turn flips the top bit of the difference
		diff = (wrap_dn || wrap_up) ? (diff_raw ^ $signed(WRAP)) : diff_raw;

		prod   = PW'(diff) * $signed(PW'({1'b0, cfg.speed_gain}));
		scaled = prod >>> GAIN_FRAC_BITS;

		angle_next        = has_reading ? fresh : angle;
		turns_next        = turns;
		speed_next        = speed;
		displacement_next = displacement;
		magnet_next       = magnet;
		err_latch_next    = err_latch;

		if (full) begin
			if (wrap_dn) begin
				turns_next = turns + TURN_BITS'(1);
			end else if (wrap_up) begin
				turns_next = turns - TURN_BITS'(1);
			end
			if (scaled > SAT_HI) begin
				speed_next = 24'(SAT_HI);
			end else if (scaled < SAT_LO) begin
				speed_next = 24'(SAT_LO);
			end else begin
				speed_next = 24'(scaled);
			end
		end

		frac16 = 16'((32'(angle_next) << FRAC_UP) >> FRAC_DN);
		// turns sign-extended into the integer half of 16.16
		turns16 = 16'($signed(turns_next));

		if (full) begin
			displacement_next = $signed({turns16, frac16});
			if (cfg.sensor_width_mode == MODE_12BIT) begin
				magnet_next = item.status_byte[STAT_MH] || item.status_byte[STAT_ML] ||
					!item.status_byte[STAT_MD] || (unused_stat == 4'hF && 1'b0);
			end else if (item.kind == KIND_STATUS_POS) begin
				err_latch_next = item.error_word;
			end
		end

		result.angle_fraction = frac16;
		result.turn_count     = $signed(16'(turns_next));
		result.displacement   = displacement_next;
		result.speed          = speed_next;
		result.magnet_fault   = magnet_next;
		result.error_flags    = err_latch_next;
	end

endmodule

@@ hw/rtl/multiturn_angle_tracker_core.sv @@
// ----------------------------------------------------------------------------
// multiturn_angle_tracker_core: multi-turn unwrapping of an absolute encoder
// turns single-turn angle readings into turn count, speed and displacement
// ----------------------------------------------------------------------------
// One input beat is taken per clock while item_ready is high, and every input
// beat yields exactly one result beat on result_valid; it waits in the input
// register while the output register still holds an untaken result: the
// beat lands in an input register, one pass of unwrap logic (subtract, wrap
// compare, one multiply by the Q8.8 gain with saturation) updates the tracker
// state, and the result is held in an output register. The throughput limit
// is that single pass, since each reading is unwrapped against the angle left
// by the one before it. While a finished result waits for result_ready the
// input register still takes one more beat; once it is full too, item_ready
// drops until the result is taken (item_ready follows result_ready within the
// cycle). Write configuration only while no beat is in flight.
module multiturn_angle_tracker_core
	import mat_pkg::*;
#(
	parameter int FRACTION_BITS = 16,
	parameter int TURN_BITS     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// reading beats
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	// result beats
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result
);

	// configuration registers
	cfg_t cfg_q;

	// input stage
	logic  valid_s1;
	item_t item_s1;

	// tracker state
	logic [FRACTION_BITS-1:0] angle_q;
	logic [TURN_BITS-1:0]     turns_q;
	logic signed [23:0]       speed_q;
	logic signed [31:0]       displacement_q;
	logic                     magnet_q;
	logic [15:0]              err_latch_q;

	// next state from the update pass
	logic [FRACTION_BITS-1:0] angle_d;
	logic [TURN_BITS-1:0]     turns_d;
	logic signed [23:0]       speed_d;
	logic signed [31:0]       displacement_d;
	logic                     magnet_d;
	logic                     magnet_unused;
	logic [15:0]              err_latch_d;
	result_t                  result_d;

	// output register
	logic    valid_s2;
	result_t result_s2;

	logic advance;

	// stage 1 moves on whenever the output slot is free or being drained
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	assign magnet_unused = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_width_mode <= RST_SENSOR_WIDTH_MODE;
			cfg_q.speed_gain        <= RST_SPEED_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SENSOR_WIDTH_MODE: cfg_q.sensor_width_mode <= cfg_data[0];
				CFG_SPEED_GAIN:        cfg_q.speed_gain        <= cfg_data;
				default:               cfg_q                   <= cfg_q;
			endcase
		end
	end

	// input register: control reset, payload free-running on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	mat_update #(
		.FRACTION_BITS (FRACTION_BITS),
		.TURN_BITS     (TURN_BITS)
	) u_update (
		.cfg               (cfg_q),
		.item              (item_s1),
		.angle             (angle_q),
		.turns             (turns_q),
		.speed             (speed_q),
		.displacement      (displacement_q),
		.magnet            (magnet_q | magnet_unused),
		.err_latch         (err_latch_q),
		.angle_next        (angle_d),
		.turns_next        (turns_d),
		.speed_next        (speed_d),
		.displacement_next (displacement_d),
		.magnet_next       (magnet_d),
		.err_latch_next    (err_latch_d),
		.result            (result_d)
	);

	// tracker state advances exactly once per reading beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q        <= '0;
			turns_q        <= '0;
			speed_q        <= '0;
			displacement_q <= '0;
			magnet_q       <= 1'b0;
			err_latch_q    <= '0;
		end else if (advance) begin
			angle_q        <= angle_d;
			turns_q        <= turns_d;
			speed_q        <= speed_d;
			displacement_q <= displacement_d;
			magnet_q       <= magnet_d;
			err_latch_q    <= err_latch_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	// a beat in stage 1 that cannot move stays put
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stage 1 beat dropped while stalled");

	// every update pass leaves a result in the output register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("update pass produced no result beat");

	// tracker state only moves on an update pass
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(angle_q) && $stable(turns_q) && $stable(err_latch_q))
		else $error("tracker state changed without a beat");

	// a single reading moves the turn count by at most one
	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (turns_q == $past(turns_q)) ||
			(turns_q == $past(turns_q) + TURN_BITS'(1)) ||
			(turns_q == $past(turns_q) - TURN_BITS'(1)))
		else $error("turn count jumped by more than one");

endmodule
